// File: hw/rtl/lru_pkg.sv
// Shared constants, types and helper functions for the LRU page replacement block.
package lru_pkg;

   localparam int MAX_FRAMES  = 8;
   localparam int PAGE_BITS   = 16;
   localparam int FRAME_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int RANK_W      = FRAME_W;
   localparam int CNT_W       = 16;
   localparam int CFG_W       = 4;
   localparam int OUT_FRAME_W = 3;

   typedef logic [PAGE_BITS-1:0]                  page_type;
   typedef logic [FRAME_W-1:0]                    frame_type;
   typedef logic [RANK_W-1:0]                     rank_type;
   typedef logic [CNT_W-1:0]                      count_type;
   typedef logic [CFG_W-1:0]                      cfg_type;
   typedef logic [MAX_FRAMES-1:0]                 flag_type;
   typedef logic [MAX_FRAMES-1:0][PAGE_BITS-1:0]  page_arr_type;
   typedef logic [MAX_FRAMES-1:0][RANK_W-1:0]     rank_arr_type;

   localparam cfg_type   CFG_RESET = CFG_W'(5);
   localparam rank_type  RANK_MAX  = RANK_W'(MAX_FRAMES - 1);
   localparam count_type COUNT_MAX = '1;

   typedef struct packed {
      logic      hit;
      logic      fill;
      logic      evict;
      frame_type frame;
      rank_type  old_rank;
      page_type  evicted_page;
   } decision_type;

   // A count of zero behaves as one frame; counts above the frame total cover all frames.
   function automatic flag_type active_mask(input cfg_type cfg);
      flag_type mask;
      mask = '0;
      for (int g = 0; g < MAX_FRAMES; g++) begin
         if (cfg == '0) begin
            mask[g] = (g == 0);
         end else begin
            mask[g] = (32'(cfg) > g);
         end
      end
      return mask;
   endfunction

endpackage

// File: hw/rtl/lru_req_if.sv
// Request channel carrying one page reference per beat.
interface lru_req_if;
   import lru_pkg::*;

   logic     valid;
   logic     ready;
   page_type page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

// File: hw/rtl/lru_rsp_if.sv
// Response channel carrying the lookup outcome and counters per beat.
interface lru_rsp_if;
   import lru_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [OUT_FRAME_W-1:0] frame_index;
   logic                   evicted_valid;
   page_type               evicted_page;
   count_type              miss_total;
   count_type              access_total;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output miss_total, output access_total,
                   input ready);
   modport sink (input valid, input hit, input frame_index, input evicted_valid,
                 input evicted_page, input miss_total, input access_total,
                 output ready);
endinterface

// File: hw/rtl/lru_csr_if.sv
// Configuration write channel carrying the frame count register.
interface lru_csr_if;
   import lru_pkg::*;

   logic    valid;
   logic    ready;
   cfg_type frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink (input valid, input frames_in_use, output ready);
endinterface

// File: hw/rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: channel registers, frame state and counters.
//
// The block keeps a small fully associative set of page frames and answers one
// page reference per request beat with one response beat. A response gives hit
// or miss, the frame that now holds the page, the page evicted if any, and
// saturating miss and access counts that include this reference.
// A request beat is registered, looked up against all active frames
// combinationally and written to the response register. One request is
// accepted per cycle while the receiver keeps up; the compare and age
// update across every frame is combinational and sets that rate.
// The response register and the request register decouple the two sides, so
// a new request is still taken while a finished response waits. When the
// receiver stalls, both registers fill and the request side then stalls too.
// The configuration channel writes the active frame count and is always ready;
// write it only while no request is in flight.
// Reset empties all frames, clears ages and counters and sets the count to five.
module lru_page_replacement (
   input logic       clock,
   input logic       reset,
   lru_req_if.sink   req_bus,
   lru_rsp_if.source rsp_bus,
   lru_csr_if.sink   csr_bus
);
   import lru_pkg::*;

   cfg_type      frames_cfg_ff;
   logic         s1_valid_ff;
   page_type     s1_page_ff;
   logic         rsp_valid_ff;
   logic         rsp_hit_ff;
   frame_type    rsp_frame_ff;
   logic         rsp_evicted_valid_ff;
   page_type     rsp_evicted_page_ff;
   count_type    miss_ff;
   count_type    miss_in;
   count_type    access_ff;
   count_type    access_in;
   flag_type     frame_valid_ff;
   flag_type     frame_valid_in;
   rank_arr_type frame_rank_ff;
   rank_arr_type frame_rank_in;
   page_arr_type frame_page_ff;
   flag_type     active;
   decision_type decision;
   logic         advance;

   assign active  = active_mask(frames_cfg_ff);
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   assign req_bus.ready = !s1_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   lru_select u_select (
      .page        (s1_page_ff),
      .active      (active),
      .frame_valid (frame_valid_ff),
      .frame_page  (frame_page_ff),
      .frame_rank  (frame_rank_ff),
      .decision    (decision)
   );

   always_comb begin
      frame_valid_in = frame_valid_ff;
      frame_rank_in  = frame_rank_ff;
      if (decision.fill) begin
         frame_valid_in[decision.frame] = 1'b1;
      end
      for (int g = 0; g < MAX_FRAMES; g++) begin
         if (FRAME_W'(g) == decision.frame) begin
            frame_rank_in[g] = '0;
         end else if (active[g] && frame_valid_ff[g] && frame_rank_ff[g] < decision.old_rank
                      && frame_rank_ff[g] != RANK_MAX) begin
            frame_rank_in[g] = frame_rank_ff[g] + RANK_W'(1);
         end
      end
      access_in = (access_ff != COUNT_MAX) ? access_ff + CNT_W'(1) : access_ff;
      miss_in   = (!decision.hit && miss_ff != COUNT_MAX) ? miss_ff + CNT_W'(1) : miss_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_cfg_ff  <= CFG_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         miss_ff        <= '0;
         access_ff      <= '0;
         frame_valid_ff <= '0;
         frame_rank_ff  <= '0;
      end else begin
         if (csr_bus.valid) begin
            frames_cfg_ff <= csr_bus.frames_in_use;
         end
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            miss_ff        <= miss_in;
            access_ff      <= access_in;
            frame_valid_ff <= frame_valid_in;
            frame_rank_ff  <= frame_rank_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_page_ff <= req_bus.page_number;
      end
      if (advance) begin
         rsp_hit_ff           <= decision.hit;
         rsp_frame_ff         <= decision.frame;
         rsp_evicted_valid_ff <= decision.evict;
         rsp_evicted_page_ff  <= decision.evicted_page;
         if (!decision.hit) begin
            frame_page_ff[decision.frame] <= s1_page_ff;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = rsp_hit_ff;
   assign rsp_bus.frame_index   = OUT_FRAME_W'(rsp_frame_ff);
   assign rsp_bus.evicted_valid = rsp_evicted_valid_ff;
   assign rsp_bus.evicted_page  = rsp_evicted_page_ff;
   assign rsp_bus.miss_total    = miss_ff;
   assign rsp_bus.access_total  = access_ff;

endmodule

// File: hw/rtl/lru_select.sv
// Frame selection: hit search, empty frame search and least recently used victim choice.
module lru_select (
   input  lru_pkg::page_type     page,
   input  lru_pkg::flag_type     active,
   input  lru_pkg::flag_type     frame_valid,
   input  lru_pkg::page_arr_type frame_page,
   input  lru_pkg::rank_arr_type frame_rank,
   output lru_pkg::decision_type decision
);
   import lru_pkg::*;

   logic      hit_found;
   frame_type hit_idx;
   logic      empty_found;
   frame_type empty_idx;
   frame_type victim_idx;
   rank_type  victim_rank;

   always_comb begin
      hit_found   = 1'b0;
      hit_idx     = '0;
      empty_found = 1'b0;
      empty_idx   = '0;
      victim_idx  = '0;
      victim_rank = frame_rank[0];
      for (int g = 0; g < MAX_FRAMES; g++) begin
         if (!hit_found && active[g] && frame_valid[g] && frame_page[g] == page) begin
            hit_found = 1'b1;
            hit_idx   = FRAME_W'(g);
         end
         if (!empty_found && active[g] && !frame_valid[g]) begin
            empty_found = 1'b1;
            empty_idx   = FRAME_W'(g);
         end
      end
      for (int g = 1; g < MAX_FRAMES; g++) begin
         if (active[g] && frame_rank[g] > victim_rank) begin
            victim_idx  = FRAME_W'(g);
            victim_rank = frame_rank[g];
         end
      end
   end

   always_comb begin
      decision              = '0;
      decision.hit          = hit_found;
      decision.fill         = !hit_found && empty_found;
      decision.evict        = !hit_found && !empty_found;
      decision.evicted_page = '0;
      if (hit_found) begin
         decision.frame    = hit_idx;
         decision.old_rank = frame_rank[hit_idx];
      end else if (empty_found) begin
         decision.frame    = empty_idx;
         decision.old_rank = RANK_MAX;
      end else begin
         decision.frame        = victim_idx;
         decision.old_rank     = victim_rank;
         decision.evicted_page = frame_page[victim_idx];
      end
   end

endmodule

// File: test/tb_lru_page_replacement.sv
// Self-checking testbench for the LRU page replacement block with a built-in frame predictor.
module tb_lru_page_replacement;
   import lru_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int QUIET_FIRST = 250;
   localparam int QUIET_LAST  = 400;
   localparam int PRESSURE_AT = 500;
   localparam int PRESSURE_CYCLES = 60;

   typedef enum logic {BEAT_REF, BEAT_CFG} beat_kind_type;

   typedef struct {
      beat_kind_type kind;
      page_type      value;
   } beat_item_type;

   typedef struct packed {
      logic                   hit;
      logic [OUT_FRAME_W-1:0] frame_index;
      logic                   evicted_valid;
      page_type               evicted_page;
      count_type              miss_total;
      count_type              access_total;
   } lookup_type;

   logic clock;
   logic reset;

   lru_req_if req_bus ();
   lru_rsp_if rsp_bus ();
   lru_csr_if csr_bus ();

   lru_page_replacement u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   beat_item_type pending_beats[$];
   lookup_type    predicted_lookups[$];

   cfg_type   model_frames;
   page_type  model_page [MAX_FRAMES];
   logic      model_resident [MAX_FRAMES];
   rank_type  model_age [MAX_FRAMES];
   count_type model_misses;
   count_type model_accesses;

   int refs_sent;
   int lookups_seen;
   int fault_count;
   int hold_left;
   bit pressure_done;
   int idle_cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_frames(input cfg_type cfg);
      if (cfg == '0) begin
         return 1;
      end
      return (int'(cfg) > MAX_FRAMES) ? MAX_FRAMES : int'(cfg);
   endfunction

   function automatic lookup_type predict_lookup(input page_type page);
      lookup_type res;
      int         n;
      int         f;
      int         i;
      int         prior_age;
      bit         found;
      res = '0;
      n = active_frames(model_frames);
      f = 0;
      found = 1'b0;
      if (model_accesses != COUNT_MAX) model_accesses++;
      for (i = 0; i < n; i++) begin
         if (!found && model_resident[i] && model_page[i] == page) begin
            f = i;
            found = 1'b1;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         prior_age = int'(model_age[f]);
      end else begin
         if (model_misses != COUNT_MAX) model_misses++;
         for (i = 0; i < n; i++) begin
            if (!found && !model_resident[i]) begin
               f = i;
               found = 1'b1;
            end
         end
         if (found) begin
            model_resident[f] = 1'b1;
            prior_age = MAX_FRAMES - 1;
         end else begin
            f = 0;
            for (i = 1; i < n; i++) begin
               if (model_age[i] > model_age[f]) f = i;
            end
            res.evicted_valid = 1'b1;
            res.evicted_page = model_page[f];
            prior_age = int'(model_age[f]);
         end
         model_page[f] = page;
      end
      for (i = 0; i < n; i++) begin
         if (i != f && model_resident[i] && int'(model_age[i]) < prior_age &&
             model_age[i] != RANK_MAX) begin
            model_age[i] = model_age[i] + 1'b1;
         end
      end
      model_age[f] = '0;
      res.frame_index = OUT_FRAME_W'(f);
      res.miss_total = model_misses;
      res.access_total = model_accesses;
      return res;
   endfunction

   task automatic add_ref(input page_type page);
      beat_item_type item;
      item.kind = BEAT_REF;
      item.value = page;
      pending_beats.push_back(item);
   endtask

   task automatic add_cfg(input cfg_type cfg);
      beat_item_type item;
      item.kind = BEAT_CFG;
      item.value = page_type'(cfg);
      pending_beats.push_back(item);
   endtask

   task automatic add_random_phase(input cfg_type cfg, input int count);
      page_type pool [12];
      int       pool_size;
      pool_size = active_frames(cfg) + 2 + $urandom_range(2);
      for (int i = 0; i < pool_size; i++) begin
         pool[i] = page_type'($urandom);
      end
      add_cfg(cfg);
      repeat (count) begin
         if ($urandom_range(99) < 80) begin
            add_ref(pool[$urandom_range(pool_size - 1)]);
         end else begin
            add_ref(page_type'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin : drive_proc
      logic     next_req_valid;
      page_type next_page;
      logic     next_csr_valid;
      cfg_type  next_cfg;
      bit       quiet;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
      end else begin
         next_req_valid = req_bus.valid;
         next_page = req_bus.page_number;
         next_csr_valid = csr_bus.valid;
         next_cfg = csr_bus.frames_in_use;
         if (req_bus.valid && req_bus.ready) begin
            predicted_lookups.push_back(predict_lookup(req_bus.page_number));
            refs_sent++;
            next_req_valid = 1'b0;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            model_frames = csr_bus.frames_in_use;
            next_csr_valid = 1'b0;
         end
         if (!next_req_valid && !next_csr_valid && pending_beats.size() != 0) begin
            quiet = (refs_sent >= QUIET_FIRST && refs_sent < QUIET_LAST);
            if (pending_beats[0].kind == BEAT_CFG) begin
               // The frame count only changes once every lookup in flight has come back.
               if (predicted_lookups.size() == 0 && !req_bus.valid) begin
                  next_csr_valid = 1'b1;
                  next_cfg = cfg_type'(pending_beats[0].value);
                  void'(pending_beats.pop_front());
               end
            end else if (quiet || $urandom_range(99) >= 17) begin
               next_req_valid = 1'b1;
               next_page = pending_beats[0].value;
               void'(pending_beats.pop_front());
            end
         end
         req_bus.valid <= next_req_valid;
         req_bus.page_number <= next_page;
         csr_bus.valid <= next_csr_valid;
         csr_bus.frames_in_use <= next_cfg;
      end
   end

   always @(posedge clock) begin : check_proc
      lookup_type seen;
      lookup_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.hit = rsp_bus.hit;
            seen.frame_index = rsp_bus.frame_index;
            seen.evicted_valid = rsp_bus.evicted_valid;
            seen.evicted_page = rsp_bus.evicted_page;
            seen.miss_total = rsp_bus.miss_total;
            seen.access_total = rsp_bus.access_total;
            if (predicted_lookups.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $display("Unexpected response beat: hit=%0d frame=%0d ev=%0d/%h miss=%0d acc=%0d",
                           seen.hit, seen.frame_index, seen.evicted_valid, seen.evicted_page,
                           seen.miss_total, seen.access_total);
               end
            end else begin
               want = predicted_lookups.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS) begin
                     $display("Mismatch on response %0d:", lookups_seen);
                     $display("  expected hit=%0d frame=%0d ev=%0d/%h miss=%0d acc=%0d",
                              want.hit, want.frame_index, want.evicted_valid,
                              want.evicted_page, want.miss_total, want.access_total);
                     $display("  actual   hit=%0d frame=%0d ev=%0d/%h miss=%0d acc=%0d",
                              seen.hit, seen.frame_index, seen.evicted_valid,
                              seen.evicted_page, seen.miss_total, seen.access_total);
                  end
               end
            end
            lookups_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!pressure_done && lookups_seen == PRESSURE_AT) begin
            // Hold the response side off long enough for the block to back up its requests.
            pressure_done = 1'b1;
            hold_left = PRESSURE_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (lookups_seen >= QUIET_FIRST && lookups_seen < QUIET_LAST) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin : watchdog_proc
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.page_number = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.frames_in_use = '0;
      model_frames = CFG_RESET;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         model_page[i] = '0;
         model_resident[i] = 1'b0;
         model_age[i] = '0;
      end
      model_misses = '0;
      model_accesses = '0;
      refs_sent = 0;
      lookups_seen = 0;
      fault_count = 0;
      hold_left = 0;
      pressure_done = 1'b0;
      idle_cycles = 0;

      // Directed part: fill, eviction, shrinking and growing the frame set, clamped counts.
      add_ref(16'h0000);
      add_ref(16'hFFFF);
      add_ref(16'h0000);
      add_ref(16'h0001);
      add_ref(16'h0002);
      add_ref(16'h0003);
      add_ref(16'h0004);
      add_ref(16'hFFFF);
      add_cfg(4'd8);
      add_ref(16'h0005);
      add_ref(16'h0006);
      add_ref(16'h0007);
      add_ref(16'h8000);
      add_ref(16'h1234);
      add_cfg(4'd2);
      add_ref(16'h1234);
      add_ref(16'h0007);
      add_ref(16'hAAAA);
      add_cfg(4'd15);
      add_ref(16'h0007);
      add_ref(16'h5555);
      add_cfg(4'd0);
      add_ref(16'h5555);
      add_ref(16'h5555);
      add_ref(16'h0009);
      add_cfg(4'd1);
      add_ref(16'h0009);

      add_random_phase(4'd3, 60);
      add_random_phase(4'd8, 60);
      add_random_phase(4'd1, 60);
      add_random_phase(4'd6, 60);
      add_random_phase(4'd9, 60);
      add_random_phase(4'd2, 60);
      add_random_phase(4'd0, 60);
      add_random_phase(4'd7, 280);

      add_cfg(4'd5);
      repeat (20) add_ref(page_type'($urandom_range(7)));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending_beats.size() != 0 || req_bus.valid || csr_bus.valid ||
                 predicted_lookups.size() != 0);
      repeat (8) @(posedge clock);

      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: lru_page_replacement.f
hw/rtl/lru_pkg.sv
hw/rtl/lru_req_if.sv
hw/rtl/lru_rsp_if.sv
hw/rtl/lru_csr_if.sv
hw/rtl/lru_select.sv
hw/rtl/lru_page_replacement.sv
test/tb_lru_page_replacement.sv
